// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on clk, quiet while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: hw/rtl/dosc_pkg.sv
// Types, constants and saturation helpers for the Duffing oscillator RK4 stepper.
package dosc_pkg;

    localparam int DATA_W    = 32;
    localparam int HIGH_W    = 31;
    localparam int STEP_W    = 17;
    localparam int COEFF_W   = 21;
    localparam int CFG_W     = 21;
    localparam int REG_IDX_W = 2;
    localparam int OPND_W    = 33;
    localparam int WIDE_W    = 2 * OPND_W;
    localparam int SUM_W     = 35;
    localparam int DIV_DIG   = 5;
    localparam int DIV_STEPS = SUM_W / DIV_DIG;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DAMPING   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CUBIC     = 2'd2;

    localparam logic [3:0] DIVISOR = 4'd6;

    typedef logic [1:0]               stage_t;
    typedef logic signed [DATA_W-1:0] fx_t;
    typedef logic signed [OPND_W-1:0] opnd_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [SUM_W-1:0]  ksum_t;

    localparam stage_t FULL_STAGE = 2'd2;
    localparam stage_t LAST_STAGE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KX,
        ST_X2,
        ST_X3,
        ST_CUB,
        ST_DMP,
        ST_ACC,
        ST_KV,
        ST_ARG,
        ST_DIV,
        ST_UPD
    } dosc_state_t;

    // True when the value does not fit the signed 32-bit range.
    function automatic logic clips32(input wide_t v);
        return !((&v[WIDE_W-1:DATA_W-1]) || (~|v[WIDE_W-1:DATA_W-1]));
    endfunction

    function automatic fx_t sat32(input wide_t v);
        fx_t r;
        if (clips32(v))
            r = v[WIDE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

// File: hw/rtl/dosc_in_if.sv
// Input channel: one forcing sample and the restart flag per transfer.
interface dosc_in_if import dosc_pkg::*; ();
    logic  valid;
    logic  ready;
    fx_t   drive_force;
    logic  restart;

    modport source (output valid, output drive_force, output restart, input ready);
    modport sink   (input valid, input drive_force, input restart, output ready);
endinterface

// File: hw/rtl/dosc_out_if.sv
// Result channel: new state, running extremes and the clip flag per transfer.
interface dosc_out_if import dosc_pkg::*; ();
    logic              valid;
    logic              ready;
    fx_t               displacement;
    fx_t               velocity;
    fx_t               disp_low;
    logic [HIGH_W-1:0] disp_high;
    fx_t               vel_low;
    logic [HIGH_W-1:0] vel_high;
    logic              saturated;

    modport source (output valid, output displacement, output velocity,
                    output disp_low, output disp_high, output vel_low,
                    output vel_high, output saturated, input ready);
    modport sink   (input valid, input displacement, input velocity,
                    input disp_low, input disp_high, input vel_low,
                    input vel_high, input saturated, output ready);
endinterface

// File: hw/rtl/dosc_mul.sv
// Shared signed fixed-point multiplier with registered product and floor shift.
module dosc_mul import dosc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic  clk,
    input  logic  en,
    input  opnd_t op_a,
    input  opnd_t op_b,
    output wide_t prod_shr
);

    wide_t prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    // Arithmetic shift rounds toward minus infinity.
    assign prod_shr = prod_reg >>> FRAC_BITS;

endmodule

// File: hw/rtl/dosc_div6.sv
// Two-lane divide by six, truncating toward zero, DIV_DIG quotient bits per cycle while busy.
module dosc_div6 import dosc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  ksum_t num_x,
    input  ksum_t num_v,
    output logic  done,
    output ksum_t quo_x,
    output ksum_t quo_v
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 neg_reg [2];
    logic [SUM_W-1:0]     mag_reg [2];
    logic [SUM_W-1:0]     quo_reg [2];
    logic [2:0]           rem_reg [2];

    logic [SUM_W-1:0]     mag_next [2];
    logic [SUM_W-1:0]     quo_next [2];
    logic [2:0]           rem_next [2];
    ksum_t                num [2];

    assign num[0] = num_x;
    assign num[1] = num_v;

    // Long division: shift one numerator bit into the remainder, subtract six if it fits.
    always_comb
    begin
        logic [3:0] part;
        for (int ln = 0; ln < 2; ln++)
        begin
            mag_next[ln] = mag_reg[ln];
            quo_next[ln] = quo_reg[ln];
            rem_next[ln] = rem_reg[ln];
            for (int d = 0; d < DIV_DIG; d++)
            begin
                part = {rem_next[ln], mag_next[ln][SUM_W-1]};
                mag_next[ln] = {mag_next[ln][SUM_W-2:0], 1'b0};
                if (part >= DIVISOR)
                begin
                    part = part - DIVISOR;
                    quo_next[ln] = {quo_next[ln][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next[ln] = {quo_next[ln][SUM_W-2:0], 1'b0};
                end
                rem_next[ln] = part[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int ln = 0; ln < 2; ln++)
        begin
            if (start)
            begin
                neg_reg[ln] <= num[ln][SUM_W-1];
                mag_reg[ln] <= num[ln][SUM_W-1] ? SUM_W'(-num[ln]) : SUM_W'(num[ln]);
                quo_reg[ln] <= '0;
                rem_reg[ln] <= '0;
            end
            else if (busy_reg)
            begin
                mag_reg[ln] <= mag_next[ln];
                quo_reg[ln] <= quo_next[ln];
                rem_reg[ln] <= rem_next[ln];
            end
        end
    end

    assign done  = done_reg;
    assign quo_x = neg_reg[0] ? -$signed(quo_reg[0]) : $signed(quo_reg[0]);
    assign quo_v = neg_reg[1] ? -$signed(quo_reg[1]) : $signed(quo_reg[1]);

endmodule

// File: hw/rtl/duffing_oscillator_rk4_step.sv
// Duffing oscillator RK4 stepper: top level with sequencer and datapath.
// A sample is accepted only in idle, so each one finishes before the next is taken.
// Each runs 24 multiplies on the one shared multiplier, one sum and one argument step
// per stage, and the divide by six.
// Reset clears state, extremes and control; the step, damping and cubic registers take their defaults.
`include "assert_macros.svh"

module duffing_oscillator_rk4_step import dosc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    dosc_in_if.sink              sample,
    dosc_out_if.source           result
);

    localparam longint unsigned ONE_FX = 64'd1 << FRAC_BITS;
    localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'((ONE_FX + 64'd50) / 64'd100);
    localparam logic [COEFF_W-1:0] DAMP_RST  = COEFF_W'((ONE_FX + 64'd5) / 64'd10);
    localparam logic [COEFF_W-1:0] CUBIC_RST = COEFF_W'((64'd3 * ONE_FX + 64'd5) / 64'd10);
    localparam int DMP_W = 54 - FRAC_BITS;

    // Control and state
    dosc_state_t         state_reg, state_next;
    logic                phase_reg;
    stage_t              stage_reg;
    logic                out_valid_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [COEFF_W-1:0]  damp_reg;
    logic [COEFF_W-1:0]  cubic_reg;
    fx_t                 disp_reg, vel_reg;
    fx_t                 dmin_reg, dmax_reg, vmin_reg, vmax_reg;

    // Working values
    fx_t                 force_reg;
    fx_t                 xa_reg, va_reg;
    fx_t                 t_reg;
    logic signed [DMP_W-1:0] dmp_reg;
    fx_t                 kx_reg, kv_reg;
    ksum_t               sumx_reg, sumv_reg;
    logic                clip_reg;

    // Result payload
    fx_t                 disp_out_reg, vel_out_reg;
    fx_t                 dmin_out_reg, vmin_out_reg;
    logic [HIGH_W-1:0]   dmax_out_reg, vmax_out_reg;
    logic                sat_out_reg;

    // Sequencer outputs
    logic                in_ready;
    logic                mul_en;
    opnd_t               op_a, op_b;
    logic                div_start;
    logic                upd_go;
    logic                accept;

    // Datapath nets
    wide_t               mul_out;
    fx_t                 mul_sat;
    logic                mul_clip;
    wide_t               acc_sum;
    ksum_t               kx_w, kv_w;
    ksum_t               sumx_next, sumv_next;
    wide_t               xarg, varg;
    logic                div_done;
    ksum_t               quo_x, quo_v;
    wide_t               disp_sum, vel_sum;
    fx_t                 disp_new, vel_new;
    fx_t                 dmin_next, dmax_next, vmin_next, vmax_next;
    logic                clip_final;

    assign accept = sample.valid && in_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (sample.valid) state_next = ST_KX;
            ST_KX:   if (phase_reg) state_next = ST_X2;
            ST_X2:   if (phase_reg) state_next = ST_X3;
            ST_X3:   if (phase_reg) state_next = ST_CUB;
            ST_CUB:  if (phase_reg) state_next = ST_DMP;
            ST_DMP:  if (phase_reg) state_next = ST_ACC;
            ST_ACC:  state_next = ST_KV;
            ST_KV:   if (phase_reg) state_next = ST_ARG;
            ST_ARG:  state_next = (stage_reg == LAST_STAGE) ? ST_DIV : ST_KX;
            ST_DIV:  if (div_done) state_next = ST_UPD;
            ST_UPD:  if (!out_valid_reg || result.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: operand routing for the shared multiplier
    always_comb
    begin
        in_ready  = 1'b0;
        mul_en    = 1'b0;
        op_a      = '0;
        op_b      = '0;
        div_start = 1'b0;
        upd_go    = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_KX:
            begin
                mul_en = !phase_reg;
                op_a   = opnd_t'({{(OPND_W-STEP_W){1'b0}}, step_reg});
                op_b   = opnd_t'(va_reg);
            end
            ST_X2:
            begin
                mul_en = !phase_reg;
                op_a   = opnd_t'(xa_reg);
                op_b   = opnd_t'(xa_reg);
            end
            ST_X3:
            begin
                mul_en = !phase_reg;
                op_a   = opnd_t'(t_reg);
                op_b   = opnd_t'(xa_reg);
            end
            ST_CUB:
            begin
                mul_en = !phase_reg;
                op_a   = opnd_t'({{(OPND_W-COEFF_W){1'b0}}, cubic_reg});
                op_b   = opnd_t'(t_reg);
            end
            ST_DMP:
            begin
                mul_en = !phase_reg;
                op_a   = opnd_t'({{(OPND_W-COEFF_W){1'b0}}, damp_reg});
                op_b   = opnd_t'(va_reg);
            end
            ST_KV:
            begin
                mul_en = !phase_reg;
                op_a   = opnd_t'({{(OPND_W-STEP_W){1'b0}}, step_reg});
                op_b   = opnd_t'(t_reg);
            end
            ST_ARG:  div_start = (stage_reg == LAST_STAGE);
            ST_UPD:  upd_go = !out_valid_reg || result.ready;
            default: ;
        endcase
    end

    dosc_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk      (clk),
        .en       (mul_en),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_shr (mul_out)
    );

    assign mul_sat  = sat32(mul_out);
    assign mul_clip = clips32(mul_out);

    assign acc_sum = wide_t'(force_reg) - wide_t'(dmp_reg) - wide_t'(xa_reg) - wide_t'(t_reg);

    // Middle stages count twice in the weighted sum
    always_comb
    begin
        kx_w = ksum_t'(kx_reg);
        kv_w = ksum_t'(kv_reg);
        if (stage_reg == 2'd1 || stage_reg == FULL_STAGE)
        begin
            kx_w = kx_w <<< 1;
            kv_w = kv_w <<< 1;
        end
    end

    assign sumx_next = sumx_reg + kx_w;
    assign sumv_next = sumv_reg + kv_w;

    // The third stage feeds the full increment, the first two half of it
    assign xarg = wide_t'(disp_reg) + ((stage_reg == FULL_STAGE) ? wide_t'(kx_reg)
                                                                 : (wide_t'(kx_reg) >>> 1));
    assign varg = wide_t'(vel_reg) + ((stage_reg == FULL_STAGE) ? wide_t'(kv_reg)
                                                                : (wide_t'(kv_reg) >>> 1));

    dosc_div6 u_div6 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num_x (sumx_next),
        .num_v (sumv_next),
        .done  (div_done),
        .quo_x (quo_x),
        .quo_v (quo_v)
    );

    assign disp_sum   = wide_t'(disp_reg) + wide_t'(quo_x);
    assign vel_sum    = wide_t'(vel_reg) + wide_t'(quo_v);
    assign disp_new   = sat32(disp_sum);
    assign vel_new    = sat32(vel_sum);
    assign clip_final = clip_reg || clips32(disp_sum) || clips32(vel_sum);
    assign dmin_next  = (disp_new < dmin_reg) ? disp_new : dmin_reg;
    assign dmax_next  = (disp_new > dmax_reg) ? disp_new : dmax_reg;
    assign vmin_next  = (vel_new < vmin_reg) ? vel_new : vmin_reg;
    assign vmax_next  = (vel_new > vmax_reg) ? vel_new : vmax_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            stage_reg     <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= STEP_RST;
            damp_reg      <= DAMP_RST;
            cubic_reg     <= CUBIC_RST;
            disp_reg      <= '0;
            vel_reg       <= '0;
            dmin_reg      <= '0;
            dmax_reg      <= '0;
            vmin_reg      <= '0;
            vmax_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= mul_en;
            if (state_reg == ST_ARG)
            begin
                stage_reg <= stage_reg + 1'b1;
            end

            if (wr_en)
            begin
                case (wr_index)
                    REG_STEP_SIZE: step_reg  <= wr_data[STEP_W-1:0];
                    REG_DAMPING:   damp_reg  <= wr_data[COEFF_W-1:0];
                    REG_CUBIC:     cubic_reg <= wr_data[COEFF_W-1:0];
                    default:       ;
                endcase
            end

            if (accept && sample.restart)
            begin
                disp_reg <= '0;
                vel_reg  <= '0;
            end

            if (upd_go)
            begin
                disp_reg      <= disp_new;
                vel_reg       <= vel_new;
                dmin_reg      <= dmin_next;
                dmax_reg      <= dmax_next;
                vmin_reg      <= vmin_next;
                vmax_reg      <= vmax_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    force_reg <= sample.drive_force;
                    xa_reg    <= sample.restart ? '0 : disp_reg;
                    va_reg    <= sample.restart ? '0 : vel_reg;
                    sumx_reg  <= '0;
                    sumv_reg  <= '0;
                    clip_reg  <= 1'b0;
                end
            end
            ST_KX:
            begin
                if (phase_reg)
                begin
                    kx_reg   <= mul_sat;
                    clip_reg <= clip_reg | mul_clip;
                end
            end
            ST_X2, ST_X3, ST_CUB:
            begin
                if (phase_reg)
                begin
                    t_reg    <= mul_sat;
                    clip_reg <= clip_reg | mul_clip;
                end
            end
            ST_DMP:
            begin
                if (phase_reg)
                begin
                    dmp_reg <= mul_out[DMP_W-1:0];
                end
            end
            ST_ACC:
            begin
                t_reg    <= sat32(acc_sum);
                clip_reg <= clip_reg | clips32(acc_sum);
            end
            ST_KV:
            begin
                if (phase_reg)
                begin
                    kv_reg   <= mul_sat;
                    clip_reg <= clip_reg | mul_clip;
                end
            end
            ST_ARG:
            begin
                sumx_reg <= sumx_next;
                sumv_reg <= sumv_next;
                if (stage_reg != LAST_STAGE)
                begin
                    xa_reg   <= sat32(xarg);
                    va_reg   <= sat32(varg);
                    clip_reg <= clip_reg | clips32(xarg) | clips32(varg);
                end
            end
            ST_UPD:
            begin
                if (upd_go)
                begin
                    disp_out_reg <= disp_new;
                    vel_out_reg  <= vel_new;
                    dmin_out_reg <= dmin_next;
                    dmax_out_reg <= dmax_next[HIGH_W-1:0];
                    vmin_out_reg <= vmin_next;
                    vmax_out_reg <= vmax_next[HIGH_W-1:0];
                    sat_out_reg  <= clip_final;
                end
            end
            default: ;
        endcase
    end

    assign sample.ready        = in_ready;
    assign result.valid        = out_valid_reg;
    assign result.displacement = disp_out_reg;
    assign result.velocity     = vel_out_reg;
    assign result.disp_low     = dmin_out_reg;
    assign result.disp_high    = dmax_out_reg;
    assign result.vel_low      = vmin_out_reg;
    assign result.vel_high     = vmax_out_reg;
    assign result.saturated    = sat_out_reg;

    `ASSERT_CLK(a_extremes_sign, (dmin_reg <= 0) && (dmax_reg >= 0) && (vmin_reg <= 0) && (vmax_reg >= 0), "running extremes crossed zero")
    `ASSERT_CLK(a_result_from_update, $rose(out_valid_reg) |-> $past(state_reg == ST_UPD), "result raised outside the update step")
    `ASSERT_NEVER(a_div_done_stray, div_done && (state_reg != ST_DIV), "divider finished while the sequencer was not waiting")
    `ASSERT_CLK(a_idle_clean, (state_reg == ST_IDLE) |-> (!phase_reg && (stage_reg == 2'd0)), "sequencer idle with a stage or phase pending")

endmodule
